@@ hw/rtl/dh_modular_exponentiation_32_unit_assert.svh @@
// Assertion macros shared by the modular exponentiation RTL.
// In synthesis builds the macros expand to nothing.
`ifndef DH_MODULAR_EXPONENTIATION_32_UNIT_ASSERT_SVH
`define DH_MODULAR_EXPONENTIATION_32_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define DHME_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define DHME_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define DHME_ASSERT(lbl, clk, rst_n, prop, msg)

`define DHME_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

@@ hw/rtl/dhme_pkg.sv @@
`default_nettype none

package dhme_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned BitCntW = $clog2(DataW);

  localparam logic [BitCntW-1:0] BitCntLast = BitCntW'(DataW - 1);

  localparam logic [DataW-1:0] ModulusReset   = 32'hFFFF_FFFB;
  localparam logic [DataW-1:0] GeneratorReset = 32'd5;

  typedef enum logic {
    OP_PUBLIC = 1'b0,
    OP_SHARED = 1'b1
  } opcode_e;

  typedef enum logic {
    REG_MODULUS   = 1'b0,
    REG_GENERATOR = 1'b1
  } reg_idx_e;

  // Request to the modular multiplier: result = a * b mod m, with a < m.
  typedef struct packed {
    logic             start;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DataW-1:0] result;
  } mm_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/dhme_mulmod.sv @@
`default_nettype none

`include "dh_modular_exponentiation_32_unit_assert.svh"

// Interleaved modular multiplier: one bit of b per cycle, most significant
// first. Each step computes 2r + bit*a, which stays below 3m, and takes off
// m or 2m as needed, so no intermediate value grows past 34 bits.
module dhme_mulmod (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dhme_pkg::mm_req_t                  req_i,
  input  logic [dhme_pkg::DataW-1:0]         m_i,
  output dhme_pkg::mm_sts_t                  sts_o
);
  import dhme_pkg::*;

  localparam int unsigned SumW = DataW + 2;

  logic [DataW-1:0]   r_q, r_d;
  logic [DataW-1:0]   a_q, a_d;
  logic [DataW-1:0]   b_q, b_d;
  logic [BitCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  logic [SumW-1:0] sum;
  logic [SumW-1:0] m1;
  logic [SumW-1:0] m2;
  logic [SumW-1:0] sub1;
  logic [SumW-1:0] sub2;
  logic [DataW-1:0] r_step;

  assign m1   = {2'b00, m_i};
  assign m2   = {1'b0, m_i, 1'b0};
  assign sum  = {1'b0, r_q, 1'b0} + (b_q[DataW-1] ? {2'b00, a_q} : '0);
  assign sub1 = sum - m1;
  assign sub2 = sum - m2;

  always_comb begin
    if (sum >= m2) begin
      r_step = sub2[DataW-1:0];
    end else if (sum >= m1) begin
      r_step = sub1[DataW-1:0];
    end else begin
      r_step = sum[DataW-1:0];
    end
  end

  always_comb begin
    r_d    = r_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      r_d    = '0;
      a_d    = req_i.a;
      b_d    = req_i.b;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d   = r_step;
      b_d   = {b_q[DataW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == BitCntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    a_q <= a_d;
    b_q <= b_d;
  end

  assign sts_o.busy   = busy_q;
  assign sts_o.done   = done_q;
  assign sts_o.result = r_q;

  `DHME_ASSERT(a_last_step_done, clk_i, rst_ni,
               (busy_q && !req_i.start && cnt_q == BitCntLast) |=> done_q,
               "multiplier missed its done pulse")
  `DHME_ASSERT(a_result_reduced, clk_i, rst_ni, done_q |-> (r_q < m_i),
               "multiplier result not below modulus")
  `DHME_NEVER(a_done_while_busy, clk_i, rst_ni, done_q && busy_q,
              "multiplier done while still busy")

endmodule

`default_nettype wire

@@ hw/rtl/dh_modular_exponentiation_32_unit.sv @@
// Computes base^exponent mod modulus for 32-bit Diffie-Hellman: opcode 0
// uses the generator register as base, opcode 1 the peer key. One shared
// add-and-double modular multiplier does all arithmetic, one operand bit
// per cycle. With a modulus of two or more, the base reduction and 32
// squarings always run, plus one multiply per set exponent bit. A modulus
// below two gives 0, offered in the cycle after the input transfer. The
// block takes one item at a time; in_ready_o is low from the transfer of an
// item until its result has been transferred out. Configuration writes are
// allowed only while the block is idle.
`default_nettype none

`include "dh_modular_exponentiation_32_unit_assert.svh"

module dh_modular_exponentiation_32_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [dhme_pkg::DataW-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       opcode_i,
  input  logic [dhme_pkg::DataW-1:0] exponent_i,
  input  logic [dhme_pkg::DataW-1:0] peer_key_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [dhme_pkg::DataW-1:0] result_o
);
  import dhme_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REDUCE = 5'b00010,
    ST_SQR    = 5'b00100,
    ST_MUL    = 5'b01000,
    ST_OUT    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [DataW-1:0]   modulus_q;
  logic [DataW-1:0]   generator_q;
  logic [DataW-1:0]   mod_q, mod_d;
  logic [DataW-1:0]   acc_q, acc_d;
  logic [DataW-1:0]   base_q, base_d;
  logic [DataW-1:0]   exp_q, exp_d;
  logic [BitCntW-1:0] cnt_q, cnt_d;
  logic               start_q, start_d;
  logic [DataW-1:0]   op_a_q, op_a_d;
  logic [DataW-1:0]   op_b_q, op_b_d;

  logic    in_fire;
  logic    advance;
  mm_req_t mm_req;
  mm_sts_t mm_sts;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_OUT);
  assign result_o    = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= ModulusReset;
      generator_q <= GeneratorReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MODULUS:   modulus_q   <= cfg_data_i;
        REG_GENERATOR: generator_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign mm_req.start = start_q;
  assign mm_req.a     = op_a_q;
  assign mm_req.b     = op_b_q;

  dhme_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .m_i    (mod_q),
    .sts_o  (mm_sts)
  );

  always_comb begin
    state_d = state_q;
    mod_d   = mod_q;
    acc_d   = acc_q;
    base_d  = base_q;
    exp_d   = exp_q;
    cnt_d   = cnt_q;
    start_d = 1'b0;
    op_a_d  = op_a_q;
    op_b_d  = op_b_q;
    advance = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          exp_d = exponent_i;
          cnt_d = BitCntLast;
          mod_d = modulus_q;
          if (modulus_q < DataW'(2)) begin
            acc_d   = '0;
            state_d = ST_OUT;
          end else begin
            // Reduce the base as 1 * base mod m on the multiplier.
            start_d = 1'b1;
            op_a_d  = DataW'(1);
            op_b_d  = (opcode_e'(opcode_i) == OP_SHARED) ? peer_key_i : generator_q;
            state_d = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_sts.done) begin
          base_d  = mm_sts.result;
          acc_d   = DataW'(1);
          start_d = 1'b1;
          op_a_d  = DataW'(1);
          op_b_d  = DataW'(1);
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mm_sts.done) begin
          acc_d = mm_sts.result;
          if (exp_q[DataW-1]) begin
            start_d = 1'b1;
            op_a_d  = base_q;
            op_b_d  = mm_sts.result;
            state_d = ST_MUL;
          end else begin
            advance = 1'b1;
          end
        end
      end
      ST_MUL: begin
        if (mm_sts.done) begin
          acc_d   = mm_sts.result;
          advance = 1'b1;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Move on to the next exponent bit, or finish after the last one.
    if (advance) begin
      if (cnt_q == '0) begin
        state_d = ST_OUT;
      end else begin
        cnt_d   = cnt_q - 1'b1;
        exp_d   = {exp_q[DataW-2:0], 1'b0};
        start_d = 1'b1;
        op_a_d  = mm_sts.result;
        op_b_d  = mm_sts.result;
        state_d = ST_SQR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      start_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mod_q  <= mod_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    exp_q  <= exp_d;
    op_a_q <= op_a_d;
    op_b_q <= op_b_d;
  end

  `DHME_ASSERT(a_start_when_free, clk_i, rst_ni, start_q |-> !mm_sts.busy,
               "multiply started while the multiplier is busy")
  `DHME_ASSERT(a_operands_reduced, clk_i, rst_ni,
               (state_q == ST_SQR || state_q == ST_MUL) |->
                 (acc_q < mod_q && base_q < mod_q),
               "accumulator or base not reduced during exponentiation")
  `DHME_NEVER(a_done_unexpected, clk_i, rst_ni,
              mm_sts.done && (state_q == ST_IDLE || state_q == ST_OUT),
              "multiplier finished with no multiply pending")
  `DHME_ASSERT(a_start_leaves_idle, clk_i, rst_ni,
               start_q |-> (state_q == ST_REDUCE || state_q == ST_SQR ||
                            state_q == ST_MUL),
               "multiply started outside the exponentiation states")

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import dhme_pkg::*;

  localparam int unsigned HalfPeriodNs   = 6;
  localparam int unsigned ResetCycles    = 11;
  localparam int unsigned LongHoldCycles = 5000;
  localparam int unsigned MaxReports     = 10;
  localparam int unsigned DirectedCount  = 20;
  localparam int unsigned DrainCycles    = 20;
  localparam longint unsigned CycleLimit = 64'd4_000_000;

  typedef struct {
    opcode_e          op;
    logic [DataW-1:0] exponent;
    logic [DataW-1:0] peer_key;
    bit               known;
    logic [DataW-1:0] result;
  } directed_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic             cfg_idx_i   = 1'b0;
  logic [DataW-1:0] cfg_data_i  = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic             opcode_i    = 1'b0;
  logic [DataW-1:0] exponent_i  = '0;
  logic [DataW-1:0] peer_key_i  = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [DataW-1:0] result_o;

  // Local copies of the block's configuration registers.
  logic [DataW-1:0] modulus_q   = ModulusReset;
  logic [DataW-1:0] generator_q = GeneratorReset;

  logic [DataW-1:0] pending_powers [$];
  directed_row_t    directed_rows [DirectedCount];

  int unsigned mismatches     = 0;
  int unsigned unexpected     = 0;
  int unsigned results_seen   = 0;
  int unsigned items_sent     = 0;
  int unsigned shared_sent    = 0;
  int unsigned settings_used  = 1;
  bit          calm           = 1'b0;
  bit          hold_request   = 1'b0;

  dh_modular_exponentiation_32_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .exponent_i  (exponent_i),
    .peer_key_i  (peer_key_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_o)
  );

  always begin
    #HalfPeriodNs clk_i = 1'b1;
    #HalfPeriodNs clk_i = 1'b0;
  end

  // Square-and-multiply from the top exponent bit down, every product reduced.
  function automatic logic [DataW-1:0] power_mod(input logic [DataW-1:0] base,
                                                 input logic [DataW-1:0] exponent,
                                                 input logic [DataW-1:0] modulus);
    logic [63:0] acc;
    logic [63:0] b;
    int          i;
    if (modulus < 2) begin
      return '0;
    end
    b   = 64'(base % modulus);
    acc = 64'd1;
    for (i = DataW - 1; i >= 0; i--) begin
      acc = (acc * acc) % 64'(modulus);
      if (exponent[i]) begin
        acc = (acc * b) % 64'(modulus);
      end
    end
    return acc[DataW-1:0];
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(100, 400);
  endfunction

  task automatic send_item(input opcode_e op, input logic [DataW-1:0] exponent,
                           input logic [DataW-1:0] peer_key, input bit known,
                           input logic [DataW-1:0] result);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    exponent_i <= exponent;
    peer_key_i <= peer_key;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (known) begin
      pending_powers.push_back(result);
    end else begin
      pending_powers.push_back(power_mod((op == OP_SHARED) ? peer_key : generator_q,
                                         exponent, modulus_q));
    end
    items_sent++;
    if (op == OP_SHARED) shared_sent++;
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MODULUS) begin
      modulus_q = data;
    end else begin
      generator_q = data;
    end
  endtask

  task automatic run_phase(input logic [DataW-1:0] modulus, input logic [DataW-1:0] generator,
                           input int unsigned count, input bit quiet, input bit long_hold);
    opcode_e          op;
    logic [DataW-1:0] exponent;
    logic [DataW-1:0] peer_key;
    write_reg(REG_MODULUS, modulus);
    write_reg(REG_GENERATOR, generator);
    settings_used++;
    calm = quiet;
    if (long_hold) hold_request = 1'b1;
    repeat (count) begin
      op = $urandom_range(0, 1) ? OP_SHARED : OP_PUBLIC;
      case ($urandom_range(0, 9))
        0:       exponent = $urandom_range(0, 3);
        1:       exponent = 32'd1 << $urandom_range(0, 31);
        2:       exponent = '1;
        3:       exponent = $urandom & $urandom;
        default: exponent = $urandom;
      endcase
      // Bases near the modulus exercise the initial reduction.
      case ($urandom_range(0, 9))
        0:       peer_key = modulus_q;
        1:       peer_key = modulus_q - 1;
        2:       peer_key = modulus_q + $urandom_range(1, 3);
        3:       peer_key = $urandom_range(0, 2);
        4:       peer_key = '1;
        default: peer_key = $urandom;
      endcase
      send_item(op, exponent, peer_key, 1'b0, '0);
    end
    wait_for_results();
  endtask

  initial begin : result_sink
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LongHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left  = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 200)
                                                   : $urandom_range(0, 5);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    logic [DataW-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_powers.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= MaxReports) begin
          $display("%0t: result %h arrived with nothing outstanding", $realtime, result_o);
        end
      end else begin
        want = pending_powers.pop_front();
        if (want !== result_o) begin
          mismatches++;
          if (mismatches + unexpected <= MaxReports) begin
            $display("%0t: result mismatch: expected %h, got %h", $realtime, want, result_o);
          end
        end
      end
    end
  end

  initial begin : watchdog
    longint unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Run timed out after %0d cycles", cycles);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int               i;
    logic [DataW-1:0] rand_mod;
    // Reset settings: the modulus is the prime 2^32 - 5 and the generator is 5.
    directed_rows = '{
      '{OP_PUBLIC, 32'd0,          32'd0,          1'b1, 32'd1},
      '{OP_SHARED, 32'd0,          32'hFFFF_FFFF,  1'b1, 32'd1},
      '{OP_PUBLIC, 32'd1,          32'd0,          1'b1, 32'd5},
      '{OP_PUBLIC, 32'd2,          32'hFFFF_FFFF,  1'b1, 32'd25},
      '{OP_SHARED, 32'd1,          32'd0,          1'b1, 32'd0},
      '{OP_SHARED, 32'hFFFF_FFFF,  32'd1,          1'b1, 32'd1},
      '{OP_SHARED, 32'd7,          32'hFFFF_FFFB,  1'b1, 32'd0},
      '{OP_SHARED, 32'd1,          32'hFFFF_FFFF,  1'b1, 32'd4},
      '{OP_SHARED, 32'd1,          32'hFFFF_FFFC,  1'b1, 32'd1},
      '{OP_SHARED, 32'hFFFF_FFFA,  32'd2,          1'b1, 32'd1},
      '{OP_PUBLIC, 32'hFFFF_FFFA,  32'd0,          1'b1, 32'd1},
      '{OP_SHARED, 32'd1,          32'hFFFF_FFFA,  1'b1, 32'hFFFF_FFFA},
      '{OP_SHARED, 32'd2,          32'hFFFF_FFFA,  1'b1, 32'd1},
      '{OP_SHARED, 32'd3,          32'hFFFF_FFFA,  1'b1, 32'hFFFF_FFFA},
      '{OP_SHARED, 32'd1,          32'h1234_5678,  1'b1, 32'h1234_5678},
      '{OP_SHARED, 32'hFFFF_FFFF,  32'hAAAA_AAAA,  1'b0, 32'd0},
      '{OP_PUBLIC, 32'hFFFF_FFFF,  32'd0,          1'b0, 32'd0},
      '{OP_SHARED, 32'h8000_0000,  32'h5555_5555,  1'b0, 32'd0},
      '{OP_PUBLIC, 32'h5A5A_5A5A,  32'hFFFF_FFFF,  1'b0, 32'd0},
      '{OP_SHARED, 32'hA5A5_A5A5,  32'hDEAD_BEEF,  1'b0, 32'd0}
    };
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DirectedCount; i++) begin
      send_item(directed_rows[i].op, directed_rows[i].exponent, directed_rows[i].peer_key,
                directed_rows[i].known, directed_rows[i].result);
    end
    wait_for_results();

    // The first phase opens with a long output stall so the block backs up.
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 40, 1'b0, 1'b1);
    run_phase(32'd2, 32'd0, 25, 1'b1, 1'b0);
    run_phase(ModulusReset, 32'd0, 20, 1'b0, 1'b0);
    for (i = 0; i < 4; i++) begin
      rand_mod = $urandom;
      if (rand_mod < 2) rand_mod = 32'd2;
      run_phase(rand_mod, $urandom, 30, (i == 2), 1'b0);
    end
    run_phase(32'd7, 32'd3, 20, 1'b0, 1'b0);
    run_phase($urandom_range(2, 1000), $urandom, 15, 1'b0, 1'b0);
    // A modulus below two has no meaning and yields zero.
    run_phase(32'd1, GeneratorReset, 8, 1'b0, 1'b0);
    run_phase(32'd0, GeneratorReset, 8, 1'b0, 1'b0);
    run_phase(32'h8000_0000, 32'hFFFF_FFFE, 20, 1'b1, 1'b0);

    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d items (%0d shared-secret, %0d public-key) over %0d register settings,",
             items_sent, shared_sent, items_sent - shared_sent, settings_used);
    $display("checked %0d results: %0d mismatches, %0d unexpected, %0d outstanding.",
             results_seen, mismatches, unexpected, pending_powers.size());
    if (mismatches == 0 && unexpected == 0 && pending_powers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
